// ===== sv/xpf_pkg.sv =====
// shared types and constants of the xor parity fec group restore block
package xpf_pkg;

	localparam int unsigned GROUP_W  = 32;
	localparam int unsigned SEQ_W    = 16;
	localparam int unsigned OFF_W    = 11;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned LEN_W    = 12;
	localparam int unsigned GSIZE_W  = 6;
	localparam int unsigned GEFF_W   = 7;
	localparam int unsigned VERD_W   = 2;
	localparam int unsigned IN_TDATA_W  = 72;
	localparam int unsigned OUT_TDATA_W = 24;

	localparam logic [VERD_W-1:0] VERD_DATA   = 2'd0;
	localparam logic [VERD_W-1:0] VERD_PARITY = 2'd1;
	localparam logic [VERD_W-1:0] VERD_DUP    = 2'd2;
	localparam logic [VERD_W-1:0] VERD_STALE  = 2'd3;

	localparam logic [GSIZE_W-1:0] GSIZE_RESET = 6'd4;

	localparam logic REQ_PACKET = 1'b0;
	localparam logic REQ_READ   = 1'b1;

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_DIVI  = 10'b0000000010,
		ST_MRD   = 10'b0000000100,
		ST_MWAIT = 10'b0000001000,
		ST_CLEAR = 10'b0000010000,
		ST_BYTE  = 10'b0000100000,
		ST_BWAIT = 10'b0001000000,
		ST_FIN   = 10'b0010000000,
		ST_RRD   = 10'b0100000000,
		ST_RWAIT = 10'b1000000000
	} state_t;

endpackage

// ===== sv/xpf_ram.sv =====
// generic single-port ram with registered read
module xpf_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ===== sv/xpf_rem.sv =====
// bit-serial remainder unit, one dividend bit per cycle
module xpf_rem #(
	parameter int unsigned DW = 9
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [31:0]   dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] rem
);
	logic          busy_q;
	logic          done_q;
	logic [4:0]    cnt_q;
	logic [31:0]   dvd_q;
	logic [DW-1:0] r_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;

	assign trial = {r_q, dvd_q[31]};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			r_q   <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			r_q   <= (trial >= {1'b0, divisor}) ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	assign done = done_q;
	assign rem  = r_q;
endmodule

// ===== sv/xor_parity_fec_group_restore_top.sv =====
// top level: fec group bookkeeping and xor parity buffer restore
//
// s_* channel: one transaction per packet byte (s_tuser = 0) or per read of one
// restored byte (s_tuser = 1); s_tlast marks a packet's final byte or the read
// that releases the restored packet. m_* channel: one transaction per packet
// final byte and per read, carrying verdict, restore status, length and byte.
// cfg_we/cfg_wdata write group_size; the user must write it only while the
// block is idle, which the block itself does not enforce.
// A byte inside a packet does a store read and an xor write back.
// The first byte of a packet picks its slot as the group modulo SLOTS at
// accept and runs the bit-serial group index remainder (seq_num-1 mod
// group_size) and the slot metadata read; when the slot is reset, a sweep
// zeroes its buffer of MAX_BYTES entries through the single store port.
// A final byte writes slot metadata back. One transaction is handled at a time.
// Reset clears the control state, all slot valid bits and the restored packet;
// buffer contents are not cleared at reset, each buffer is zeroed when its slot
// takes a new group. While m_tready is low a result waits in the output
// register and s_tready stays low until it is taken.
module xor_parity_fec_group_restore_top #(
	parameter int unsigned SLOTS     = 16,
	parameter int unsigned MAX_BYTES = 2048,
	parameter int unsigned MAX_GROUP = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [5:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// fec_group[31:0], is_parity[32], seq_num[48:33], byte_offset[59:49],
	// byte_value[67:60], zero fill
	input  logic [71:0] s_tdata,
	// req_type
	input  logic [0:0]  s_tuser,
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	// verdict[1:0], returns_parity[2], restore_ready[3], restored_length[15:4],
	// read_byte[23:16]
	output logic [23:0] m_tdata
);
	import xpf_pkg::*;

	localparam int unsigned SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned BW  = $clog2(SLOTS + 1);
	localparam int unsigned OW  = $clog2(MAX_BYTES);
	localparam int unsigned AW  = $clog2((SLOTS + 1) * MAX_BYTES);
	localparam int unsigned IW  = $clog2(MAX_GROUP);
	localparam int unsigned CW  = $clog2(MAX_GROUP + 1);
	localparam int unsigned DW  = GEFF_W;
	localparam int unsigned MW  = GROUP_W + 1 + CW + MAX_GROUP + LEN_W + BW;
	localparam int unsigned B_LO = 0;
	localparam int unsigned L_LO = BW;
	localparam int unsigned K_LO = L_LO + LEN_W;
	localparam int unsigned C_LO = K_LO + MAX_GROUP;
	localparam int unsigned P_LO = C_LO + CW;
	localparam int unsigned G_LO = P_LO + 1;
	localparam logic [31:0] MB32 = MAX_BYTES;

	state_t state_q;

	logic [GSIZE_W-1:0] gsize_q;
	logic [GEFF_W-1:0]  gs_eff;

	// latched transaction
	logic               req_q;
	logic [GROUP_W-1:0] grp_q;
	logic               par_q;
	logic [OFF_W-1:0]   off_q;
	logic [BYTE_W-1:0]  val_q;
	logic               last_q;

	// packet context
	logic               in_packet_q;
	logic [SW-1:0]      slot_q;
	logic [IW-1:0]      idx_q;
	logic [VERD_W-1:0]  dec_q;
	logic               cur_valid_q;
	logic [GROUP_W-1:0] cur_group_q;
	logic               cur_par_q;
	logic [CW-1:0]      cur_cnt_q;
	logic [MAX_GROUP-1:0] cur_mask_q;
	logic [LEN_W-1:0]   cur_len_q;
	logic [BW-1:0]      cur_bidx_q;
	logic [OW-1:0]      clr_cnt_q;

	logic               slot_valid_q [SLOTS];
	logic               bidx_set_q   [SLOTS];
	logic [BW-1:0]      spare_q;
	logic               rst_valid_q;
	logic [BW-1:0]      rst_bidx_q;
	logic [LEN_W-1:0]   rst_len_q;

	logic               m_valid_q;
	logic [OUT_TDATA_W-1:0] m_data_q;

	// remainder unit
	logic [SEQ_W-1:0]   seq_m1;
	logic               rem_start;
	logic [31:0]        rem_dvd;
	logic [DW-1:0]      rem_div;
	logic               rem_done;
	logic [DW-1:0]      rem_val;

	// metadata ram
	logic               meta_we;
	logic               meta_re;
	logic [MW-1:0]      meta_wdata;
	logic [MW-1:0]      meta_rdata;

	// byte store
	logic               st_we;
	logic               st_re;
	logic [AW-1:0]      st_addr;
	logic [BW-1:0]      st_bidx;
	logic [OW-1:0]      st_off;
	logic [BYTE_W-1:0]  st_wdata;
	logic [BYTE_W-1:0]  st_rdata;

	logic               accept;
	logic               off_ok;

	// decision from the metadata read
	logic               rd_valid;
	logic [GROUP_W-1:0] rd_group;
	logic               rd_par;
	logic [CW-1:0]      rd_cnt;
	logic [MAX_GROUP-1:0] rd_mask;
	logic [LEN_W-1:0]   rd_len;
	logic [BW-1:0]      rd_bidx;
	logic               do_clear;
	logic [GROUP_W-1:0] nx_group;
	logic               nx_par;
	logic [CW-1:0]      nx_cnt;
	logic [MAX_GROUP-1:0] nx_mask;
	logic [LEN_W-1:0]   nx_len;
	logic [VERD_W-1:0]  nx_dec;

	logic               restore;
	logic [LEN_W-1:0]   off_len;

	assign gs_eff = (gsize_q < GSIZE_W'(2)) ? GEFF_W'(2) :
		(GEFF_W'(gsize_q) > GEFF_W'(MAX_GROUP)) ? GEFF_W'(MAX_GROUP) : GEFF_W'(gsize_q);

	assign s_tready = (state_q == ST_IDLE) && (!m_valid_q || m_tready);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign off_ok   = (32'(off_q) < MB32);
	assign off_len  = LEN_W'(off_q) + LEN_W'(1);

	// seq_num-1 wraps in 16 bits
	assign seq_m1 = s_tdata[48:33] - SEQ_W'(1);

	// group index remainder starts on a packet's first byte
	always_comb begin
		rem_start = accept && (s_tuser[0] == REQ_PACKET) && !in_packet_q;
		rem_dvd   = 32'(seq_m1);
		rem_div   = gs_eff;
	end

	xpf_rem #(.DW(DW)) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (rem_dvd),
		.divisor  (rem_div),
		.done     (rem_done),
		.rem      (rem_val)
	);

	// decide the packet's fate from the slot metadata
	always_comb begin
		rd_valid = slot_valid_q[slot_q];
		rd_group = meta_rdata[G_LO +: GROUP_W];
		rd_par   = meta_rdata[P_LO];
		rd_cnt   = meta_rdata[C_LO +: CW];
		rd_mask  = meta_rdata[K_LO +: MAX_GROUP];
		rd_len   = meta_rdata[L_LO +: LEN_W];
		rd_bidx  = bidx_set_q[slot_q] ? meta_rdata[B_LO +: BW] : BW'(slot_q);
		do_clear = !rd_valid || (rd_group < grp_q);
		nx_group = do_clear ? grp_q : rd_group;
		nx_par   = do_clear ? 1'b0 : rd_par;
		nx_cnt   = do_clear ? '0 : rd_cnt;
		nx_mask  = do_clear ? '0 : rd_mask;
		nx_len   = do_clear ? '0 : rd_len;
		nx_dec   = VERD_DATA;
		if (nx_group > grp_q) begin
			nx_dec = VERD_STALE;
		end else if (par_q) begin
			if (nx_par) begin
				nx_dec = VERD_DUP;
			end else begin
				nx_dec = VERD_PARITY;
				nx_par = 1'b1;
			end
		end else if (nx_mask[idx_q]) begin
			nx_dec = VERD_DUP;
		end else begin
			nx_mask = nx_mask | (MAX_GROUP'(1) << idx_q);
			nx_cnt  = nx_cnt + CW'(1);
		end
	end

	assign restore = (dec_q <= VERD_PARITY) && cur_valid_q && cur_par_q &&
		((CW + 1)'(cur_cnt_q) + (CW + 1)'(1) == (CW + 1)'(gs_eff));

	always_comb begin
		meta_re    = (state_q == ST_MRD);
		meta_we    = (state_q == ST_FIN);
		meta_wdata = {cur_group_q, cur_par_q, cur_cnt_q, cur_mask_q, cur_len_q,
			restore ? spare_q : cur_bidx_q};
	end

	xpf_ram #(.WIDTH(MW), .DEPTH(SLOTS)) u_meta_ram (
		.clk   (clk),
		.we    (meta_we),
		.re    (meta_re),
		.addr  ($clog2(SLOTS)'(slot_q)),
		.wdata (meta_wdata),
		.rdata (meta_rdata)
	);

	// byte store port
	always_comb begin
		st_we    = 1'b0;
		st_re    = 1'b0;
		st_bidx  = cur_bidx_q;
		st_off   = OW'(off_q);
		st_wdata = st_rdata ^ val_q;
		unique case (state_q)
			ST_CLEAR: begin
				st_we    = 1'b1;
				st_off   = clr_cnt_q;
				st_wdata = '0;
			end
			ST_BYTE:  st_re = (dec_q <= VERD_PARITY) && off_ok;
			ST_BWAIT: st_we = 1'b1;
			ST_RRD: begin
				st_bidx = rst_bidx_q;
				st_re   = rst_valid_q && off_ok;
			end
			default: ;
		endcase
		st_addr = AW'(st_bidx) * AW'(MAX_BYTES) + AW'(st_off);
	end

	xpf_ram #(.WIDTH(BYTE_W), .DEPTH((SLOTS + 1) * MAX_BYTES)) u_store_ram (
		.clk   (clk),
		.we    (st_we),
		.re    (st_re),
		.addr  (st_addr),
		.wdata (st_wdata),
		.rdata (st_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			gsize_q     <= GSIZE_RESET;
			in_packet_q <= 1'b0;
			spare_q     <= BW'(SLOTS);
			rst_valid_q <= 1'b0;
			rst_bidx_q  <= '0;
			rst_len_q   <= '0;
			m_valid_q   <= 1'b0;
			for (int i = 0; i < SLOTS; i++) begin
				slot_valid_q[i] <= 1'b0;
				bidx_set_q[i]   <= 1'b0;
			end
		end else begin
			if (cfg_we) begin
				gsize_q <= cfg_wdata;
			end
			if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (s_tuser[0] == REQ_READ) begin
							state_q <= ST_RRD;
						end else if (!in_packet_q) begin
							state_q <= ST_DIVI;
						end else begin
							state_q <= ST_BYTE;
						end
					end
				end
				ST_DIVI: if (rem_done) state_q <= ST_MRD;
				ST_MRD:  state_q <= ST_MWAIT;
				ST_MWAIT: begin
					in_packet_q <= 1'b1;
					state_q     <= do_clear ? ST_CLEAR : ST_BYTE;
				end
				ST_CLEAR: begin
					if (clr_cnt_q == OW'(MAX_BYTES - 1)) begin
						state_q <= ST_BYTE;
					end
				end
				ST_BYTE: begin
					if ((dec_q <= VERD_PARITY) && off_ok) begin
						state_q <= ST_BWAIT;
					end else begin
						state_q <= last_q ? ST_FIN : ST_IDLE;
					end
				end
				ST_BWAIT: state_q <= last_q ? ST_FIN : ST_IDLE;
				ST_FIN: begin
					in_packet_q          <= 1'b0;
					slot_valid_q[slot_q] <= cur_valid_q && !restore;
					bidx_set_q[slot_q]   <= 1'b1;
					if (restore) begin
						spare_q     <= cur_bidx_q;
						rst_bidx_q  <= cur_bidx_q;
						rst_len_q   <= cur_len_q;
						rst_valid_q <= 1'b1;
					end
					m_valid_q <= 1'b1;
					state_q   <= ST_IDLE;
				end
				ST_RRD: state_q <= ST_RWAIT;
				ST_RWAIT: begin
					if (last_q) begin
						rst_valid_q <= 1'b0;
					end
					m_valid_q <= 1'b1;
					state_q   <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload and packet context registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= s_tuser[0];
			grp_q  <= s_tdata[31:0];
			par_q  <= s_tdata[32];
			off_q  <= s_tdata[59:49];
			val_q  <= s_tdata[67:60];
			last_q <= s_tlast;
		end
		if (rem_start) begin
			slot_q <= SW'(s_tdata[GROUP_W-1:0] % SLOTS);
		end
		if (state_q == ST_DIVI && rem_done) begin
			idx_q <= IW'(rem_val);
		end
		if (state_q == ST_MWAIT) begin
			dec_q       <= nx_dec;
			cur_valid_q <= 1'b1;
			cur_group_q <= nx_group;
			cur_par_q   <= nx_par;
			cur_cnt_q   <= nx_cnt;
			cur_mask_q  <= nx_mask;
			cur_len_q   <= nx_len;
			cur_bidx_q  <= rd_bidx;
			clr_cnt_q   <= '0;
		end
		if (state_q == ST_CLEAR) begin
			clr_cnt_q <= clr_cnt_q + OW'(1);
		end
		if (state_q == ST_BWAIT && off_len > cur_len_q) begin
			cur_len_q <= off_len;
		end
		if (state_q == ST_FIN) begin
			if (restore) begin
				cur_bidx_q  <= spare_q;
				cur_valid_q <= 1'b0;
			end
			m_data_q <= {BYTE_W'(0),
				(restore || rst_valid_q) ? (restore ? cur_len_q : rst_len_q) : LEN_W'(0),
				restore || rst_valid_q, par_q, dec_q};
		end
		if (state_q == ST_RWAIT) begin
			m_data_q <= {
				(rst_valid_q && off_ok && (LEN_W'(off_q) < rst_len_q)) ? st_rdata : BYTE_W'(0),
				rst_valid_q ? rst_len_q : LEN_W'(0),
				rst_valid_q, 1'b0, VERD_DATA};
		end
		if (state_q == ST_RRD && req_q != REQ_READ) begin
			dec_q <= VERD_DATA;
		end
	end
endmodule
